@@ rtl/m7pc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m7pc_pkg
// Shared types and constants of the 7-bit packing codec: register indexes,
// direction and error codes, state widths and the result beat layout.
// ---------------------------------------------------------------------------
package m7pc_pkg;

   localparam int SIZE_BITS = 16;
   localparam int TAKEN_W   = SIZE_BITS + 1;
   localparam int PROD_W    = SIZE_BITS + 4;
   localparam int ACC_W     = 15;
   localparam int CNT_W     = 4;

   localparam logic [TAKEN_W-1:0] TAKEN_MAX = {TAKEN_W{1'b1}};

   // register indexes of the write port
   localparam logic CSR_DIRECTION = 1'b0;
   localparam logic CSR_RAW_SIZE  = 1'b1;

   // direction codes
   localparam logic DIR_PACK   = 1'b0;
   localparam logic DIR_UNPACK = 1'b1;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_HIGH_BIT = 2'd1;
   localparam logic [1:0] ERR_LENGTH   = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_data;
      logic       end_of_stream;
      logic [1:0] error;
   } res_type;

   typedef struct packed {
      res_type    res0;
      res_type    res1;
      logic [1:0] count;
   } pair_type;

endpackage

@@ rtl/m7pc_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m7pc_core
// Configuration registers, stream state and the single-pass step logic that
// turns one registered input byte into up to two result beats.
// ---------------------------------------------------------------------------
module m7pc_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [m7pc_pkg::SIZE_BITS-1:0]    csr_wdata,
   input  logic                              take,
   input  logic [7:0]                        in_byte,
   input  logic                              in_last,
   output m7pc_pkg::pair_type                pair
);

   logic                               direction_ff;
   logic [m7pc_pkg::SIZE_BITS-1:0]     raw_size_ff;
   logic [m7pc_pkg::ACC_W-1:0]         acc_ff,   acc_in;
   logic [m7pc_pkg::CNT_W-1:0]         cnt_ff,   cnt_in;
   logic [m7pc_pkg::TAKEN_W-1:0]       taken_ff, taken_in;
   logic [m7pc_pkg::SIZE_BITS-1:0]     given_ff, given_in;
   logic [1:0]                         err_ff,   err_in;

   always_comb begin
      logic [m7pc_pkg::ACC_W-1:0]   pk_sum;
      logic [m7pc_pkg::ACC_W-1:0]   pk_shift;
      logic [m7pc_pkg::CNT_W-1:0]   pk_cnt;
      logic [m7pc_pkg::CNT_W-1:0]   pk_cnt1;
      logic [m7pc_pkg::ACC_W-1:0]   up_sum;
      logic [m7pc_pkg::CNT_W-1:0]   up_cnt;
      logic [m7pc_pkg::TAKEN_W-1:0] taken_inc;
      logic [m7pc_pkg::PROD_W-1:0]  prod7;
      logic [m7pc_pkg::PROD_W-1:0]  limit;
      logic                         gt;
      logic                         eq;
      logic [1:0]                   err_next;

      pair     = '0;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      taken_in = taken_ff;
      given_in = given_ff;
      err_in   = err_ff;

      pk_sum   = acc_ff | (m7pc_pkg::ACC_W'(in_byte) << cnt_ff);
      pk_cnt   = cnt_ff + 4'd8;
      pk_cnt1  = pk_cnt - 4'd7;
      pk_shift = pk_sum >> 7;

      up_sum   = acc_ff | (m7pc_pkg::ACC_W'(in_byte[6:0]) << cnt_ff);
      up_cnt   = cnt_ff + 4'd7;

      taken_inc = (taken_ff == m7pc_pkg::TAKEN_MAX) ? taken_ff : taken_ff + 1'b1;
      prod7     = (m7pc_pkg::PROD_W'(taken_inc) << 3) - m7pc_pkg::PROD_W'(taken_inc);
      limit     = (m7pc_pkg::PROD_W'(raw_size_ff) << 3) + m7pc_pkg::PROD_W'(6);
      gt        = prod7 > limit;
      eq        = !gt && ((prod7 + m7pc_pkg::PROD_W'(7)) > limit);

      err_next = err_ff;
      if (err_ff == m7pc_pkg::ERR_NONE) begin
         if (gt || (in_last && !eq)) begin
            err_next = m7pc_pkg::ERR_LENGTH;
         end else if (in_byte[7]) begin
            err_next = m7pc_pkg::ERR_HIGH_BIT;
         end
      end

      if (direction_ff == m7pc_pkg::DIR_PACK) begin
         pair.res0.out_byte = {1'b0, pk_sum[6:0]};
         pair.res0.has_data = 1'b1;
         pair.res1.out_byte = {1'b0, pk_shift[6:0]};
         pair.res1.has_data = 1'b1;
         if (pk_cnt1 >= 4'd7) begin
            pair.count = 2'd2;
            acc_in     = pk_sum >> 14;
            cnt_in     = '0;
         end else begin
            pair.count = in_last ? 2'd2 : 2'd1;
            acc_in     = pk_shift;
            cnt_in     = pk_cnt1;
         end
         if (in_last) begin
            pair.res1.end_of_stream = 1'b1;
         end
      end else begin
         taken_in = taken_inc;
         err_in   = err_next;
         if ((err_next == m7pc_pkg::ERR_NONE) && (given_ff < raw_size_ff)) begin
            if (up_cnt >= 4'd8) begin
               pair.count         = 2'd1;
               pair.res0.out_byte = up_sum[7:0];
               pair.res0.has_data = 1'b1;
               acc_in             = up_sum >> 8;
               cnt_in             = up_cnt - 4'd8;
               given_in           = given_ff + 1'b1;
            end else begin
               acc_in = up_sum;
               cnt_in = up_cnt;
            end
         end
         if (in_last) begin
            pair.count              = 2'd1;
            pair.res0.error         = err_next;
            pair.res0.end_of_stream = 1'b1;
         end
      end

      if (in_last) begin
         acc_in   = '0;
         cnt_in   = '0;
         taken_in = '0;
         given_in = '0;
         err_in   = m7pc_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= m7pc_pkg::DIR_PACK;
         raw_size_ff  <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         taken_ff     <= '0;
         given_ff     <= '0;
         err_ff       <= m7pc_pkg::ERR_NONE;
      end else if (csr_we) begin
         if (csr_index == m7pc_pkg::CSR_DIRECTION) begin
            direction_ff <= csr_wdata[0];
         end else begin
            raw_size_ff <= csr_wdata;
         end
         acc_ff   <= '0;
         cnt_ff   <= '0;
         taken_ff <= '0;
         given_ff <= '0;
         err_ff   <= m7pc_pkg::ERR_NONE;
      end else if (take) begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         taken_ff <= taken_in;
         given_ff <= given_in;
         err_ff   <= err_in;
      end
   end

endmodule

@@ rtl/m7pc_outbuf.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m7pc_outbuf
// Two-slot result register: loads the beats of one step and drains them one
// beat per cycle onto the result channel while rsp_tready is high.
// ---------------------------------------------------------------------------
module m7pc_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  m7pc_pkg::pair_type   pair,
   input  logic                 take,
   output logic                 can_load,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // out_byte
   output logic [2:0]           rsp_tuser,   // has_data, error[1:0]
   output logic                 rsp_tlast    // end_of_stream
);

   m7pc_pkg::res_type slot0_ff, slot1_ff;
   logic [1:0]        count_ff, count_in;
   logic              pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign can_load   = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);

   assign rsp_tdata = slot0_ff.out_byte;
   assign rsp_tuser = {slot0_ff.error, slot0_ff.has_data};
   assign rsp_tlast = slot0_ff.end_of_stream;

   always_comb begin
      count_in = count_ff;
      if (take) begin
         count_in = pair.count;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         slot0_ff <= pair.res0;
         slot1_ff <= pair.res1;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

endmodule

@@ rtl/midi7_bit_packing_codec_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// midi7_bit_packing_codec_core
// Streaming repacker between 8-bit bytes and 7-bit MIDI-safe bytes, least
// significant bits first, with length and high-bit checks when unpacking.
// ---------------------------------------------------------------------------
// An input beat is held in an input register, stepped through the codec
// logic and its result beats are written to a two-slot output register, so
// the first result beat is valid once it has passed the input register and
// then the output register. The result port carries one beat per cycle while
// rsp_tready is high: packing gives one or two beats per input byte and can
// take a new byte while the last beat of the previous byte drains, unpacking
// gives at most one beat per byte and sustains one byte per cycle while the
// result channel does not stall. A last byte always gives at least one beat,
// with rsp_tlast set on its final beat; when unpacking, that beat carries the
// stream's error code and may hold no data (has_data low). Any register write restarts the stream state.
// ---------------------------------------------------------------------------
module midi7_bit_packing_codec_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [m7pc_pkg::SIZE_BITS-1:0]    csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // in_byte
   input  logic                              req_tlast,   // last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // out_byte
   output logic [2:0]                        rsp_tuser,   // has_data, error[1:0]
   output logic                              rsp_tlast    // end_of_stream
);

   logic               in_vld_ff, in_vld_in;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   logic               can_load;
   logic               take;
   logic               req_beat;
   m7pc_pkg::pair_type pair;

   assign take       = in_vld_ff && can_load;
   assign req_tready = !in_vld_ff || take;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_beat) begin
         in_vld_in = 1'b1;
      end else if (take) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   m7pc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .pair      (pair)
   );

   m7pc_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .pair       (pair),
      .take       (take),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/midi7_codec_monitor.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// midi7_codec_monitor
// Watches the register port and both streams of the 7-bit packing codec,
// keeps its own copy of the codec state, works out the result beats each
// accepted input byte should give and compares every result beat, field by
// field, with the oldest of them. Reports the beats still awaited and the
// number of failures.
// ---------------------------------------------------------------------------
module midi7_codec_monitor
   import m7pc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [SIZE_BITS-1:0] csr_wdata,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [7:0]           rsp_tdata,
   input  logic [2:0]           rsp_tuser,
   input  logic                 rsp_tlast,
   output int                   pending,
   output int                   fail_count
);

   logic                 cfg_dir;
   logic [SIZE_BITS-1:0] cfg_raw_size;
   logic [ACC_W-1:0]     acc;
   logic [CNT_W-1:0]     nbits;
   logic [TAKEN_W-1:0]   taken;
   logic [SIZE_BITS-1:0] given;
   logic [1:0]           err_seen;
   res_type              awaited_beats[$];
   int                   mismatches = 0;

   function automatic void restart_stream();
      acc      = '0;
      nbits    = '0;
      taken    = '0;
      given    = '0;
      err_seen = ERR_NONE;
   endfunction

   function automatic res_type make_beat(input logic [7:0] b, input logic valid,
                                         input logic [1:0] err);
      res_type r;
      r.out_byte      = b;
      r.has_data      = valid;
      r.end_of_stream = 1'b0;
      r.error         = err;
      return r;
   endfunction

   // works out the result beats of one input byte and queues them
   function automatic void codec_step(input logic [7:0] in_byte, input logic is_last);
      logic [31:0] wide_acc;
      logic [19:0] need;
      res_type     beats[2];
      int          n;
      n = 0;
      wide_acc = 32'(acc);
      if (cfg_dir == DIR_PACK) begin
         wide_acc = wide_acc | (32'(in_byte) << nbits);
         nbits = nbits + 4'd8;
         while (nbits >= 4'd7 && n < 2) begin
            beats[n] = make_beat({1'b0, wide_acc[6:0]}, 1'b1, ERR_NONE);
            n++;
            wide_acc = wide_acc >> 7;
            nbits = nbits - 4'd7;
         end
         if (is_last && nbits != 4'd0 && n < 2) begin
            beats[n] = make_beat({1'b0, wide_acc[6:0]}, 1'b1, ERR_NONE);
            n++;
         end
      end else begin
         need = (20'(cfg_raw_size) * 20'd8 + 20'd6) / 20'd7;
         if (taken != TAKEN_MAX) taken = taken + 1'b1;
         if (err_seen == ERR_NONE) begin
            if (20'(taken) > need || (is_last && 20'(taken) != need))
               err_seen = ERR_LENGTH;
            else if (in_byte[7])
               err_seen = ERR_HIGH_BIT;
         end
         if (err_seen == ERR_NONE && given < cfg_raw_size) begin
            wide_acc = wide_acc | (32'(in_byte[6:0]) << nbits);
            nbits = nbits + 4'd7;
            if (nbits >= 4'd8) begin
               beats[n] = make_beat(wide_acc[7:0], 1'b1, ERR_NONE);
               n++;
               wide_acc = wide_acc >> 8;
               nbits = nbits - 4'd8;
               given = given + 1'b1;
            end
         end
         if (is_last) begin
            if (n == 0) begin
               beats[0] = make_beat(8'h00, 1'b0, err_seen);
               n = 1;
            end
            beats[n-1].error = err_seen;
         end
      end
      acc = wide_acc[ACC_W-1:0];
      if (is_last) begin
         beats[n-1].end_of_stream = 1'b1;
         restart_stream();
      end
      for (int i = 0; i < n; i++) awaited_beats = {awaited_beats, beats[i]};
   endfunction

   function automatic void report_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_beat();
      res_type want;
      if (awaited_beats.size() == 0) begin
         $display("%0t: unexpected result beat, expected none, actual %0h/%0h/%0h",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
         mismatches++;
      end else begin
         want = awaited_beats.pop_front();
         report_field("out_byte", want.out_byte, rsp_tdata);
         report_field("has_data", 8'(want.has_data), 8'(rsp_tuser[0]));
         report_field("error", 8'(want.error), 8'(rsp_tuser[2:1]));
         report_field("end_of_stream", 8'(want.end_of_stream), 8'(rsp_tlast));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_dir      = DIR_PACK;
         cfg_raw_size = '0;
         restart_stream();
         awaited_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         if (csr_we) begin
            if (csr_index == CSR_DIRECTION)
               cfg_dir = csr_wdata[0];
            else
               cfg_raw_size = csr_wdata;
            restart_stream();
         end
         if (req_tvalid && req_tready) codec_step(req_tdata, req_tlast);
      end
      pending    <= awaited_beats.size();
      fail_count <= mismatches;
   end

endmodule

@@ tb/tb_midi7_bit_packing_codec_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_midi7_bit_packing_codec_core
// Drives the codec with a short directed set of packing and unpacking
// streams (flush, full groups, empty size, high bit, too long, too short,
// largest size) and then random streams, mostly well-formed, under four
// phases of sender idling and receiver stalling. Checking is done by the
// monitor beside the block; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_midi7_bit_packing_codec_core;
   import m7pc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic                 csr_index;
   logic [SIZE_BITS-1:0] csr_wdata;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic [2:0]           rsp_tuser;
   logic                 rsp_tlast;

   int                   pending;
   int                   fail_count;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   int                   beats_sent = 0;
   int                   cycles = 0;
   logic                 cur_dir = DIR_PACK;
   logic [SIZE_BITS-1:0] cur_size = '0;

   midi7_bit_packing_codec_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   midi7_codec_monitor u_monitor (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .pending    (pending),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_midi7_bit_packing_codec_core NOT OK");
         $finish;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   // hold the sender until every awaited result beat is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [SIZE_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic dir, input logic [SIZE_BITS-1:0] size);
      logic [SIZE_BITS-1:0] dir_word;
      dir_word    = SIZE_BITS'($urandom);
      dir_word[0] = dir;
      drain();
      csr_write(CSR_DIRECTION, dir_word);
      csr_write(CSR_RAW_SIZE, size);
      cur_dir  = dir;
      cur_size = size;
   endtask

   task automatic run_stream();
      logic [SIZE_BITS-1:0] size;
      logic [7:0]           b;
      int                   need;
      int                   len;
      int                   bad_at;
      int                   mode;
      if ($urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 9))
            0:       size = '0;
            1:       size = SIZE_BITS'($urandom);
            2:       size = '1;
            default: size = SIZE_BITS'($urandom_range(1, 20));
         endcase
         configure(1'($urandom_range(0, 1)), size);
      end
      mode = $urandom_range(0, 19);
      if (cur_dir == DIR_PACK) begin
         len = $urandom_range(1, 20);
         for (int i = 0; i < len; i++)
            send_beat(8'($urandom), (i == len - 1) && mode != 0);
      end else begin
         need = (int'(cur_size) * 8 + 6) / 7;
         len = need;
         if (need > 40) len = $urandom_range(1, 6);
         if (mode < 2) len = len + int'($urandom_range(0, 4)) - 2;
         if (len < 1) len = 1;
         bad_at = -1;
         if (mode == 2 || mode == 3) bad_at = $urandom_range(0, len - 1);
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 127));
            if (i == bad_at) b[7] = 1'b1;
            if (mode == 4) b = 8'($urandom);
            send_beat(b, (i == len - 1) && mode != 5);
         end
      end
   endtask

   initial begin
      int         phase_idle[4];
      int         phase_stall[4];
      int         target;
      logic [7:0] pack_seq[7];
      phase_idle  = '{0, 52, 0, 27};
      phase_stall = '{0, 0, 52, 27};
      pack_seq    = '{8'h00, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h01, 8'hFE};
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_DIRECTION;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // packing: single byte flush, then seven bytes filling whole groups
      configure(DIR_PACK, '0);
      send_beat(8'hFF, 1'b1);
      for (int i = 0; i < 7; i++) send_beat(pack_seq[i], i == 6);
      // unpacking with no raw bytes
      configure(DIR_UNPACK, '0);
      send_beat(8'h00, 1'b1);
      // exact length, then high bit
      configure(DIR_UNPACK, 16'd2);
      send_beat(8'h7F, 1'b0);
      send_beat(8'h7F, 1'b0);
      send_beat(8'h03, 1'b1);
      send_beat(8'h80, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(8'h00, 1'b1);
      // too long with output full, then too short together with high bit
      configure(DIR_UNPACK, 16'd1);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      // largest raw size, cut short
      configure(DIR_UNPACK, '1);
      send_beat(8'h7F, 1'b0);
      send_beat(8'h00, 1'b1);

      for (int p = 0; p < 4; p++) begin
         drain();
         send_idle_pct = phase_idle[p];
         stall_pct    <= phase_stall[p];
         target = beats_sent + 360;
         while (beats_sent < target) run_stream();
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_midi7_bit_packing_codec_core OK");
      else
         $display("tb_midi7_bit_packing_codec_core NOT OK");
      $finish;
   end

endmodule
